[sv/rqi_pkg.sv]
// shared types and constants for the ray and quad intersection core
package rqi_pkg;

  localparam int COORD_BITS   = 20;
  localparam int FRAC_BITS    = 10;
  localparam int DIST_BITS    = 24;
  localparam int THR_BITS     = 20;
  localparam int VERT_BITS    = 3 * COORD_BITS;
  localparam int CFG_IDX_BITS = 3;
  localparam int THR_RESET    = 1074;

  // datapath widths
  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int CP_W    = PROD_W + 1;
  localparam int CROSS_W = CP_W - FRAC_BITS;
  localparam int MUL_W   = DIFF_W + CROSS_W;
  localparam int DOT_W   = MUL_W + 3;
  localparam int DIV_W   = DOT_W + DIST_BITS + 1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_VERTEX_ZERO   = 3'd0,
    REG_VERTEX_ONE    = 3'd1,
    REG_VERTEX_TWO    = 3'd2,
    REG_VERTEX_THREE  = 3'd3,
    REG_DET_THRESHOLD = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] origin_x;
    logic signed [COORD_BITS-1:0] origin_y;
    logic signed [COORD_BITS-1:0] origin_z;
    logic signed [COORD_BITS-1:0] dir_x;
    logic signed [COORD_BITS-1:0] dir_y;
    logic signed [COORD_BITS-1:0] dir_z;
  } ray_in_t;

  typedef struct packed {
    logic                         hit;
    logic [DIST_BITS-1:0]         distance;
    logic signed [COORD_BITS-1:0] enter_x;
    logic signed [COORD_BITS-1:0] enter_y;
    logic signed [COORD_BITS-1:0] enter_z;
  } ray_out_t;

  typedef struct packed {
    logic    hit;
    ray_in_t ray;
  } side_t;

endpackage

[sv/rqi_div_pipe.sv]
// pipelined restoring divider, one quotient bit per stage, saturating
module rqi_div_pipe (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_vld,
  input  logic [rqi_pkg::DOT_W-1:0]   num,
  input  logic [rqi_pkg::DOT_W-1:0]   den,
  input  rqi_pkg::side_t              in_side,
  output logic                        out_vld,
  output logic [rqi_pkg::DIST_BITS-1:0] quo,
  output rqi_pkg::side_t              out_side
);

  localparam int NB = rqi_pkg::DIST_BITS;
  localparam int DW = rqi_pkg::DIV_W;

  logic          s_vld  [NB];
  logic          s_sat  [NB];
  logic [DW-1:0] s_rem  [NB];
  logic [DW-1:0] s_den  [NB];
  logic [NB-1:0] s_quo  [NB];
  rqi_pkg::side_t s_side [NB];

  genvar j;
  generate
    for (j = 0; j < NB; j++) begin : g_stage
      logic           vld_in;
      logic           sat_in;
      logic [DW-1:0]  rem_in;
      logic [DW-1:0]  den_in;
      logic [NB-1:0]  quo_in;
      rqi_pkg::side_t side_in;
      logic [DW-1:0]  shifted;
      logic           ge;
      logic [DW-1:0]  rem_next;
      logic [NB-1:0]  quo_next;

      if (j == 0) begin : g_first
        always_comb begin
          vld_in  = in_vld;
          rem_in  = DW'(num) << rqi_pkg::FRAC_BITS;
          den_in  = DW'(den);
          sat_in  = rem_in >= (den_in << NB);
          quo_in  = '0;
          side_in = in_side;
        end
      end else begin : g_next
        always_comb begin
          vld_in  = s_vld[j-1];
          rem_in  = s_rem[j-1];
          den_in  = s_den[j-1];
          sat_in  = s_sat[j-1];
          quo_in  = s_quo[j-1];
          side_in = s_side[j-1];
        end
      end

      always_comb begin
        shifted  = den_in << (NB - 1 - j);
        ge       = rem_in >= shifted;
        rem_next = ge ? rem_in - shifted : rem_in;
        quo_next = quo_in;
        quo_next[NB-1-j] = ge;
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          s_vld[j] <= 1'b0;
        end else begin
          s_vld[j] <= vld_in;
        end
        s_sat[j]  <= sat_in;
        s_rem[j]  <= rem_next;
        s_den[j]  <= den_in;
        s_quo[j]  <= quo_next;
        s_side[j] <= side_in;
      end
    end
  endgenerate

  assign out_vld  = s_vld[NB-1];
  assign quo      = s_sat[NB-1] ? '1 : s_quo[NB-1];
  assign out_side = s_side[NB-1];

endmodule

[sv/ray_quad_intersect_core.sv]
// ray against quad intersection core, pipelined, one ray per cycle
// an accepted start passes stages a to e, the divider, stage m and the output register before done
// throughput: one ray per cycle, every stage fed each cycle; the 24-stage divider sets the depth
// the receiver cannot stall: every result shows on done for one cycle
// synchronous reset clears all stage valids and loads the register reset values
// busy is high only while reset is applied
module ray_quad_intersect_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  rqi_pkg::ray_in_t                   ray,
  output logic                               done,
  output rqi_pkg::ray_out_t                  result,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rqi_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [rqi_pkg::VERT_BITS-1:0]      cfg_data
);

  localparam int C    = rqi_pkg::COORD_BITS;
  localparam int F    = rqi_pkg::FRAC_BITS;
  localparam int NB   = rqi_pkg::DIST_BITS;
  localparam int TB   = rqi_pkg::THR_BITS;
  localparam int DW   = rqi_pkg::DIFF_W;
  localparam int XW   = rqi_pkg::CROSS_W;
  localparam int OW   = rqi_pkg::DOT_W;
  localparam int MP_W = C + NB + 1;
  localparam int EP_W = MP_W + 1;
  localparam int LAT  = NB + 7;
  localparam logic signed [EP_W-1:0] EP_HI = EP_W'((64'sd1 <<< (C - 1)) - 64'sd1);
  localparam logic signed [EP_W-1:0] EP_LO = -EP_HI - EP_W'(1);

  typedef struct packed {
    logic signed [C-1:0] x;
    logic signed [C-1:0] y;
    logic signed [C-1:0] z;
  } vtx_t;

  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [DW-1:0] z;
  } dvec_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [XW-1:0] z;
  } cvec_t;

  typedef struct packed {
    logic signed [OW-1:0] x;
    logic signed [OW-1:0] y;
    logic signed [OW-1:0] z;
  } pvec_t;

  function automatic vtx_t unpack(input logic [rqi_pkg::VERT_BITS-1:0] r);
    vtx_t v;
    v.x = r[C-1:0];
    v.y = r[2*C-1:C];
    v.z = r[3*C-1:2*C];
    return v;
  endfunction

  function automatic dvec_t diff(input vtx_t a, input vtx_t b);
    dvec_t r;
    r.x = DW'(a.x) - DW'(b.x);
    r.y = DW'(a.y) - DW'(b.y);
    r.z = DW'(a.z) - DW'(b.z);
    return r;
  endfunction

  function automatic dvec_t dir_ext(input rqi_pkg::ray_in_t r);
    dvec_t v;
    v.x = DW'(r.dir_x);
    v.y = DW'(r.dir_y);
    v.z = DW'(r.dir_z);
    return v;
  endfunction

  function automatic logic signed [XW-1:0] cross_term(input logic signed [DW-1:0] a1,
      input logic signed [DW-1:0] b1, input logic signed [DW-1:0] a2,
      input logic signed [DW-1:0] b2);
    logic signed [rqi_pkg::PROD_W-1:0] m1;
    logic signed [rqi_pkg::PROD_W-1:0] m2;
    logic signed [rqi_pkg::CP_W-1:0]   m;
    m1 = a1 * b1;
    m2 = a2 * b2;
    m  = rqi_pkg::CP_W'(m1) - rqi_pkg::CP_W'(m2);
    return XW'(m >>> F);
  endfunction

  function automatic cvec_t cross_v(input dvec_t a, input dvec_t b);
    cvec_t r;
    r.x = cross_term(a.y, b.z, a.z, b.y);
    r.y = cross_term(a.z, b.x, a.x, b.z);
    r.z = cross_term(a.x, b.y, a.y, b.x);
    return r;
  endfunction

  function automatic logic signed [OW-1:0] mul_dc(input logic signed [DW-1:0] a,
      input logic signed [XW-1:0] b);
    logic signed [rqi_pkg::MUL_W-1:0] r;
    r = a * b;
    return OW'(r);
  endfunction

  function automatic pvec_t mulv(input dvec_t a, input cvec_t b);
    pvec_t r;
    r.x = mul_dc(a.x, b.x);
    r.y = mul_dc(a.y, b.y);
    r.z = mul_dc(a.z, b.z);
    return r;
  endfunction

  function automatic logic signed [OW-1:0] sum3(input pvec_t p);
    return p.x + p.y + p.z;
  endfunction

  function automatic logic signed [C-1:0] sat_c(input logic signed [EP_W-1:0] v);
    logic signed [EP_W-1:0] s;
    s = (v > EP_HI) ? EP_HI : ((v < EP_LO) ? EP_LO : v);
    return C'(s);
  endfunction

  function automatic logic signed [C-1:0] enter(input logic signed [C-1:0] o,
      input logic signed [MP_W-1:0] m);
    logic signed [EP_W-1:0] s;
    s = EP_W'(o) + EP_W'(m >>> F);
    return sat_c(s);
  endfunction

  // configuration registers
  logic [rqi_pkg::VERT_BITS-1:0] vertex_zero;
  logic [rqi_pkg::VERT_BITS-1:0] vertex_one;
  logic [rqi_pkg::VERT_BITS-1:0] vertex_two;
  logic [rqi_pkg::VERT_BITS-1:0] vertex_three;
  logic [TB-1:0]                 det_threshold;

  assign busy      = rst;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_zero   <= '0;
      vertex_one    <= '0;
      vertex_two    <= '0;
      vertex_three  <= '0;
      det_threshold <= TB'(rqi_pkg::THR_RESET);
    end else if (cfg_valid && cfg_ready) begin
      case (rqi_pkg::cfg_reg_t'(cfg_index))
        rqi_pkg::REG_VERTEX_ZERO:   vertex_zero   <= cfg_data;
        rqi_pkg::REG_VERTEX_ONE:    vertex_one    <= cfg_data;
        rqi_pkg::REG_VERTEX_TWO:    vertex_two    <= cfg_data;
        rqi_pkg::REG_VERTEX_THREE:  vertex_three  <= cfg_data;
        rqi_pkg::REG_DET_THRESHOLD: det_threshold <= cfg_data[TB-1:0];
        default: begin
        end
      endcase
    end
  end

  vtx_t  v0, v1, v2, v3, org;
  dvec_t e1, e3, r1, r3;
  logic [TB:0] lim_w;
  logic [TB:0] lim;

  always_comb begin
    v0 = unpack(vertex_zero);
    v1 = unpack(vertex_one);
    v2 = unpack(vertex_two);
    v3 = unpack(vertex_three);
    e1 = diff(v1, v0);
    e3 = diff(v3, v0);
    r1 = diff(v1, v2);
    r3 = diff(v3, v2);
    org.x = ray.origin_x;
    org.y = ray.origin_y;
    org.z = ray.origin_z;
    lim_w = {1'b0, det_threshold} + (TB + 1)'((1 << F) - 1);
    lim   = lim_w >> F;
  end

  // stage a: origin differences
  logic             a_vld;
  rqi_pkg::ray_in_t a_ray;
  dvec_t            a_tv, a_tp;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= start && !busy;
    end
    a_ray <= ray;
    a_tv  <= diff(org, v0);
    a_tp  <= diff(org, v2);
  end

  // stage b: cross products
  logic             b_vld;
  rqi_pkg::ray_in_t b_ray;
  dvec_t            b_tv, b_tp;
  cvec_t            b_p, b_q, b_pp, b_qp;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else begin
      b_vld <= a_vld;
    end
    b_ray <= a_ray;
    b_tv  <= a_tv;
    b_tp  <= a_tp;
    b_p   <= cross_v(dir_ext(a_ray), e3);
    b_q   <= cross_v(a_tv, e1);
    b_pp  <= cross_v(dir_ext(a_ray), r1);
    b_qp  <= cross_v(a_tp, r3);
  end

  // stage c: dot product terms
  logic             c_vld;
  rqi_pkg::ray_in_t c_ray;
  pvec_t            c_det, c_na, c_nb, c_nt, c_dp, c_ap, c_bp;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else begin
      c_vld <= b_vld;
    end
    c_ray <= b_ray;
    c_det <= mulv(e1, b_p);
    c_na  <= mulv(b_tv, b_p);
    c_nb  <= mulv(dir_ext(b_ray), b_q);
    c_nt  <= mulv(e3, b_q);
    c_dp  <= mulv(r3, b_pp);
    c_ap  <= mulv(b_tp, b_pp);
    c_bp  <= mulv(dir_ext(b_ray), b_qp);
  end

  // stage d: dot product sums
  logic                 d_vld;
  rqi_pkg::ray_in_t     d_ray;
  logic signed [OW-1:0] d_det, d_na, d_nb, d_nt, d_dp, d_ap, d_bp;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else begin
      d_vld <= c_vld;
    end
    d_ray <= c_ray;
    d_det <= sum3(c_det);
    d_na  <= sum3(c_na);
    d_nb  <= sum3(c_nb);
    d_nt  <= sum3(c_nt);
    d_dp  <= sum3(c_dp);
    d_ap  <= sum3(c_ap);
    d_bp  <= sum3(c_bp);
  end

  // stage e: sign fix and acceptance tests
  logic signed [OW-1:0] det_abs, na, nb, nt, dp_abs, ap, bp;
  logic signed [OW:0]   nab;
  logic                 small1, small2, range_bad, tri2_bad, hit_next;

  always_comb begin
    det_abs   = d_det[OW-1] ? -d_det : d_det;
    na        = d_det[OW-1] ? -d_na : d_na;
    nb        = d_det[OW-1] ? -d_nb : d_nb;
    nt        = d_det[OW-1] ? -d_nt : d_nt;
    dp_abs    = d_dp[OW-1] ? -d_dp : d_dp;
    ap        = d_dp[OW-1] ? -d_ap : d_ap;
    bp        = d_dp[OW-1] ? -d_bp : d_bp;
    nab       = (OW + 1)'(na) + (OW + 1)'(nb);
    small1    = (d_det == '0) || (det_abs < OW'(lim));
    small2    = (d_dp == '0) || (dp_abs < OW'(lim));
    range_bad = (na <= 0) || (na >= det_abs) || (nb <= 0) || (nb >= det_abs);
    tri2_bad  = (nab > (OW + 1)'(det_abs)) && (small2 || ap[OW-1] || bp[OW-1]);
    hit_next  = !small1 && !range_bad && !tri2_bad && !nt[OW-1];
  end

  logic           e_vld;
  rqi_pkg::side_t e_side;
  logic [OW-1:0]  e_num, e_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else begin
      e_vld <= d_vld;
    end
    e_side.hit <= hit_next;
    e_side.ray <= d_ray;
    e_num      <= nt;
    e_den      <= det_abs;
  end

  logic           q_vld;
  logic [NB-1:0]  q_dist;
  rqi_pkg::side_t q_side;

  rqi_div_pipe u_div (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (e_vld),
    .num      (e_num),
    .den      (e_den),
    .in_side  (e_side),
    .out_vld  (q_vld),
    .quo      (q_dist),
    .out_side (q_side)
  );

  // stage m: direction times distance
  logic                   m_vld;
  rqi_pkg::side_t         m_side;
  logic [NB-1:0]          m_dist;
  logic signed [MP_W-1:0] m_px, m_py, m_pz;
  logic signed [NB:0]     dist_s;

  assign dist_s = {1'b0, q_dist};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
    end else begin
      m_vld <= q_vld;
    end
    m_side <= q_side;
    m_dist <= q_dist;
    m_px   <= q_side.ray.dir_x * dist_s;
    m_py   <= q_side.ray.dir_y * dist_s;
    m_pz   <= q_side.ray.dir_z * dist_s;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= m_vld;
    end
    if (m_side.hit) begin
      result.hit      <= 1'b1;
      result.distance <= m_dist;
      result.enter_x  <= enter(m_side.ray.origin_x, m_px);
      result.enter_y  <= enter(m_side.ray.origin_y, m_py);
      result.enter_z  <= enter(m_side.ray.origin_z, m_pz);
    end else begin
      result <= '0;
    end
  end

`ifndef ASSERT_OFF
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done == $past(start && !busy, LAT))
    else $error("result strobe out of step with accepted transactions");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.hit) |-> (result.distance == '0 && result.enter_x == '0 &&
                               result.enter_y == '0 && result.enter_z == '0))
    else $error("miss result carries nonzero fields");

  a_thr_write: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready && cfg_index == rqi_pkg::REG_DET_THRESHOLD) |=>
    (det_threshold == $past(cfg_data[TB-1:0])))
    else $error("threshold write lost");
`endif

endmodule
